FILE: rtl/lpbf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lpbf_pkg
// Shared types and constants of the length-prefixed byte framer: channel
// payloads, the classified event that crosses the internal queue, and the
// configuration codes and reset values.
// ============================================================================
package lpbf_pkg;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] link_state;
        logic       packet_held;
    } out_item_t;

    typedef enum logic [3:0] {
        EV_TICK   = 4'b0001,
        EV_BYTE   = 4'b0010,
        EV_TXFREE = 4'b0100,
        EV_NONE   = 4'b1000
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] data;
    } event_t;

    typedef struct packed {
        logic [7:0] rx_timeout;
        logic [7:0] echo_delay;
    } cfg_t;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_BYTE   = 2'd1;
    localparam logic [1:0] MODE_TXFREE = 2'd2;

    localparam logic [1:0] LINK_IDLE = 2'd0;
    localparam logic [1:0] LINK_RX   = 2'd1;
    localparam logic [1:0] LINK_TX   = 2'd2;
    localparam logic [1:0] LINK_DROP = 2'd3;

    localparam logic CFG_RX_TIMEOUT = 1'b0;
    localparam logic CFG_ECHO_DELAY = 1'b1;

    localparam logic [7:0] RX_TIMEOUT_RST = 8'd100;
    localparam logic [7:0] ECHO_DELAY_RST = 8'd200;
    localparam logic [7:0] ASCII_ZERO     = 8'd48;
    localparam logic [7:0] TICK_MAX       = 8'd255;

endpackage

FILE: rtl/lpbf_front.sv
`timescale 1ns / 1ps
// ============================================================================
// lpbf_front
// Input side: accepts link events, decodes the mode into an event kind and
// queues them in a two-entry FIFO for the framing engine.
// ============================================================================
module lpbf_front
    import lpbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    output event_t   q_data,
    input  logic     q_pop
);

    event_t     q_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    event_t     ev_in;

    always_comb
    begin
        ev_in.data = in_data.byte_value;
        unique case (in_data.mode)
            MODE_TICK:   ev_in.kind = EV_TICK;
            MODE_BYTE:   ev_in.kind = EV_BYTE;
            MODE_TXFREE: ev_in.kind = EV_TXFREE;
            default:     ev_in.kind = EV_NONE;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= ev_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/lpbf_back.sv
`timescale 1ns / 1ps
// ============================================================================
// lpbf_back
// Framing engine: runs one queued event per pass (read cycle, then execute),
// keeps the link phase, counters and two packet banks, and registers the
// result. An echo swaps the bank roles instead of copying bytes.
// ============================================================================
module lpbf_back
    import lpbf_pkg::*;
#(
    parameter int BUFFER_BYTES = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  event_t    q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int PTR_W  = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam logic [PTR_W-1:0] BUF_P = PTR_W'(BUFFER_BYTES);
    localparam logic [7:0]       BUF_8 = 8'(BUFFER_BYTES);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_RX   = 4'b0010,
        PH_TX   = 4'b0100,
        PH_DROP = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        CT_READ = 2'b01,
        CT_EXEC = 2'b10
    } ctl_t;

    function automatic logic [1:0] link_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_RX:   code = LINK_RX;
            PH_TX:   code = LINK_TX;
            PH_DROP: code = LINK_DROP;
            default: code = LINK_IDLE;
        endcase
        return code;
    endfunction

    logic [7:0]        bank0_mem [BUFFER_BYTES];
    logic [7:0]        bank1_mem [BUFFER_BYTES];
    logic [7:0]        rd0_reg;
    logic [7:0]        rd1_reg;
    logic [7:0]        rd_data;
    logic              rd_en;

    ctl_t              ctl_reg;
    ctl_t              ctl_next;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [7:0]        tick_reg;
    logic [7:0]        tick_next;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [7:0]        left_reg;
    logic [7:0]        left_next;
    logic              full_reg;
    logic              full_next;
    logic              sel_reg;
    logic              sel_next;
    logic [ADDR_W-1:0] rx_len_reg;
    logic [ADDR_W-1:0] rx_len_next;
    logic [ADDR_W-1:0] tx_len_reg;
    logic [ADDR_W-1:0] tx_len_next;
    logic              out_valid_reg;
    out_item_t         res_reg;
    out_item_t         res_next;

    logic              commit;
    logic              wr_en;
    logic [7:0]        len8;

    assign commit    = (ctl_reg == CT_EXEC) && (!out_valid_reg || !out_stall);
    assign q_pop     = commit;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;
    assign rd_en     = (ctl_reg == CT_READ) && q_valid && (ptr_reg < BUF_P);
    assign rd_data   = sel_reg ? rd1_reg : rd0_reg;
    assign len8      = q_data.data - ASCII_ZERO;
    assign ctl_next  = (ctl_reg == CT_READ) ? (q_valid ? CT_EXEC : CT_READ)
                                            : (commit ? CT_READ : CT_EXEC);

    // One event's worth of framing; all *_next start from the held state.
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        ptr_next    = ptr_reg;
        left_next   = left_reg;
        full_next   = full_reg;
        sel_next    = sel_reg;
        rx_len_next = rx_len_reg;
        tx_len_next = tx_len_reg;
        wr_en       = 1'b0;
        res_next    = '0;

        if (q_data.kind == EV_TICK && tick_reg != TICK_MAX)
        begin
            tick_next = tick_reg + 8'd1;
        end

        // Echo due: hand the held bank to the sender and start sending.
        if (phase_reg == PH_IDLE && tick_next > cfg.echo_delay && full_reg)
        begin
            sel_next    = ~sel_reg;
            tx_len_next = rx_len_reg;
            full_next   = 1'b0;
            left_next   = 8'(rx_len_reg) + 8'd1;
            ptr_next    = '0;
            phase_next  = PH_TX;
        end

        unique case (phase_next)
            PH_IDLE:
            begin
                if (q_data.kind == EV_BYTE)
                begin
                    left_next = len8;
                    tick_next = '0;
                    if (full_next || len8 >= BUF_8)
                    begin
                        if (len8 != 8'd0)
                        begin
                            phase_next = PH_DROP;
                        end
                    end
                    else
                    begin
                        rx_len_next = len8[ADDR_W-1:0];
                        ptr_next    = PTR_W'(1);
                        if (len8 == 8'd0)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RX;
                        end
                    end
                end
            end
            PH_DROP:
            begin
                if (q_data.kind == EV_BYTE)
                begin
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                end
                else if (tick_next >= cfg.rx_timeout)
                begin
                    ptr_next   = '0;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
            PH_RX:
            begin
                if (q_data.kind == EV_BYTE)
                begin
                    wr_en     = (ptr_reg < BUF_P);
                    ptr_next  = ptr_reg + PTR_W'(1);
                    left_next = left_reg - 8'd1;
                    tick_next = '0;
                    if (left_reg == 8'd1)
                    begin
                        full_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                else if (tick_next >= cfg.rx_timeout)
                begin
                    ptr_next   = '0;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
            PH_TX:
            begin
                if (q_data.kind == EV_TXFREE && left_next != 8'd0)
                begin
                    res_next.tx_valid = 1'b1;
                    if (ptr_next == '0)
                    begin
                        res_next.tx_byte = 8'(tx_len_next) + ASCII_ZERO;
                    end
                    else if (ptr_next < BUF_P)
                    begin
                        res_next.tx_byte = rd_data;
                    end
                    if (left_next == 8'd1)
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                    ptr_next  = ptr_next + PTR_W'(1);
                    left_next = left_next - 8'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res_next.link_state  = link_code(phase_next);
        res_next.packet_held = full_next;
    end

    // Receive writes go to the bank the sender does not own.
    always_ff @(posedge clk)
    begin
        if (commit && wr_en)
        begin
            if (sel_reg)
            begin
                bank0_mem[ptr_reg[ADDR_W-1:0]] <= q_data.data;
            end
            else
            begin
                bank1_mem[ptr_reg[ADDR_W-1:0]] <= q_data.data;
            end
        end
        if (rd_en)
        begin
            rd0_reg <= bank0_mem[ptr_reg[ADDR_W-1:0]];
            rd1_reg <= bank1_mem[ptr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            res_reg    <= res_next;
            rx_len_reg <= rx_len_next;
            tx_len_reg <= tx_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= CT_READ;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            ptr_reg       <= '0;
            left_reg      <= '0;
            full_reg      <= 1'b0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (commit)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                ptr_reg   <= ptr_next;
                left_reg  <= left_next;
                full_reg  <= full_next;
                sel_reg   <= sel_next;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_exec_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg == CT_EXEC |-> q_valid)
        else $error("execute cycle without a queued event");

    a_tx_only_sending: assert property (@(posedge clk) disable iff (!rst_n)
        commit && res_next.tx_valid |-> phase_reg == PH_TX || sel_next != sel_reg)
        else $error("byte sent outside a send session");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= BUF_P)
        else $error("byte pointer beyond the packet bank");

    a_tx_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TX |-> left_reg <= BUF_8)
        else $error("send session longer than the packet bank");

    a_swap_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        commit && sel_next != sel_reg |=> !full_reg)
        else $error("bank swap left a packet marked as held");

endmodule

FILE: rtl/length_prefixed_byte_framer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// length_prefixed_byte_framer_unit
// Frames length-prefixed packets on a byte link and echoes held packets.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one link event per transfer,
// mode 0 timer tick, 1 received byte, 2 transmitter free.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// input event, in order: an optional byte to transmit, the link state and
// whether a complete packet is held.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// the receive timeout, index 1 the echo delay, in ticks; always ready.
// Events enter a two-entry queue; for each event the engine reads the
// packet bank in a read state, then executes it in an execute state and
// registers the result, finishing one event before it reads the next.
// An echo swaps bank roles within that same pass instead of copying bytes.
// Reset clears the link to idle, empties the queue and result register and
// restores the configuration defaults (100 and 200 ticks). While out_stall
// is high the result holds, the engine waits and the queue fills, then
// in_stall rises.
// ============================================================================
module length_prefixed_byte_framer_unit
    import lpbf_pkg::*;
#(
    parameter int BUFFER_BYTES = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data
);

    logic       cfg_wr;
    logic [7:0] rx_timeout_reg;
    logic [7:0] echo_delay_reg;
    logic       q_valid;
    event_t     q_data;
    logic       q_pop;
    cfg_t       cfg;

    assign cfg_ready      = 1'b1;
    assign cfg_wr         = cfg_valid && cfg_ready;
    assign cfg.rx_timeout = rx_timeout_reg;
    assign cfg.echo_delay = echo_delay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_timeout_reg <= RX_TIMEOUT_RST;
            echo_delay_reg <= ECHO_DELAY_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_RX_TIMEOUT: rx_timeout_reg <= cfg_data;
                CFG_ECHO_DELAY: echo_delay_reg <= cfg_data;
                default:        echo_delay_reg <= echo_delay_reg;
            endcase
        end
    end

    lpbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    lpbf_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
